// ===== hw/rtl/framed_packet_receiver_assert.svh =====
// Assertion macros used by the checker file.
`ifndef FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define FRP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frp assertion failed");

// Next-cycle implication, disabled while reset is high
`define FRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frp assertion failed");

`endif

// ===== hw/rtl/frp_pkg.sv =====
`timescale 1ns / 1ps

package frp_pkg;

  // Packet geometry
  localparam int MAX_PACKET = 64;
  localparam int POS_W      = $clog2(MAX_PACKET);
  localparam int LEN_W      = 7;
  localparam int BYTE_W     = 8;
  localparam int HDR_LEN    = 5;
  localparam int LEN_POS    = 3;
  localparam int ID_LO_POS  = 1;
  localparam int ID_HI_POS  = 2;
  localparam int DEST_POS   = 4;

  // Configuration register indexes
  localparam logic [1:0] REG_START   = 2'd0;
  localparam logic [1:0] REG_MAX_LEN = 2'd1;
  localparam logic [1:0] REG_MIN_LEN = 2'd2;

  // Result kinds and error codes
  localparam logic       KIND_ERROR    = 1'b0;
  localparam logic       KIND_CONTENT  = 1'b1;
  localparam logic [1:0] ERR_OUTSIDE   = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
  localparam logic [1:0] ERR_TOO_SHORT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EMIT_ERR,
    ST_EMIT_EMPTY,
    ST_PKT_READ,
    ST_PKT_LOAD
  } state_t;

  // What the captured byte leads to
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_ERROR,
    ACT_EMPTY,
    ACT_PACKET
  } act_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic rd_issue;
    logic load_err;
    logic load_empty;
    logic load_pay;
  } dp_cmd_t;

  typedef struct packed {
    act_t act;
    logic slot_free;
    logic run_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/frp_ctrl.sv =====
`timescale 1ns / 1ps

module frp_ctrl import frp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        unique case (status.act)
          ACT_ERROR:  state_next = ST_EMIT_ERR;
          ACT_EMPTY:  state_next = ST_EMIT_EMPTY;
          ACT_PACKET: state_next = ST_PKT_READ;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_EMIT_ERR: begin
        if (status.slot_free) state_next = ST_IDLE;
      end
      ST_EMIT_EMPTY: begin
        if (status.slot_free) state_next = ST_IDLE;
      end
      ST_PKT_READ: begin
        state_next = ST_PKT_LOAD;
      end
      ST_PKT_LOAD: begin
        if (status.slot_free) state_next = status.run_last ? ST_IDLE : ST_PKT_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_DECIDE:     cmd.commit     = 1'b1;
      ST_EMIT_ERR:   cmd.load_err   = status.slot_free;
      ST_EMIT_EMPTY: cmd.load_empty = status.slot_free;
      ST_PKT_READ:   cmd.rd_issue   = 1'b1;
      ST_PKT_LOAD:   cmd.load_pay   = status.slot_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/frp_datapath.sv =====
`timescale 1ns / 1ps

module frp_datapath import frp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic [7:0]  rx_byte,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        kind,
  output logic [1:0]  error_code,
  output logic [15:0] packet_id,
  output logic [7:0]  dest,
  output logic [7:0]  payload_byte,
  output logic        payload_present,
  output logic        last
);

  // Configuration
  logic [BYTE_W-1:0] start_byte;
  logic [LEN_W-1:0]  max_length;
  logic [LEN_W-1:0]  min_length;

  // Parser state
  logic [POS_W-1:0]  wp;
  logic [LEN_W-1:0]  exp_len;
  logic              in_packet;
  logic              dropping;
  logic [POS_W-1:0]  rd_idx;

  // Payload registers
  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] id_lo;
  logic [BYTE_W-1:0] id_hi;
  logic [BYTE_W-1:0] dest_q;
  logic [1:0]        err_code_q;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] store [MAX_PACKET];

  // Decision signals
  logic              is_start;
  logic              open_pkt;
  logic              take;
  logic [POS_W-1:0]  wp_eff;
  logic [LEN_W-1:0]  exp_base;
  logic [LEN_W-1:0]  exp_eff;
  logic              at_len;
  logic              too_long;
  logic              too_short;
  logic              len_err;
  logic              closing;
  logic [1:0]        err_sel;

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= '0;
      max_length <= LEN_W'(MAX_PACKET);
      min_length <= LEN_W'(HDR_LEN);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START:   start_byte <= cfg_data;
        REG_MAX_LEN: max_length <= cfg_data[LEN_W-1:0];
        REG_MIN_LEN: min_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify the captured byte
  always_comb begin
    is_start  = (byte_q == start_byte);
    open_pkt  = is_start && !in_packet;
    take      = is_start || (in_packet && !dropping);
    wp_eff    = open_pkt ? '0 : wp;
    exp_base  = open_pkt ? LEN_W'(MAX_PACKET) : exp_len;
    at_len    = (wp_eff == POS_W'(LEN_POS));
    too_long  = (byte_q > {1'b0, max_length}) || (byte_q > BYTE_W'(MAX_PACKET));
    too_short = (byte_q < {1'b0, min_length}) || (byte_q < BYTE_W'(HDR_LEN));
    len_err   = at_len && (too_long || too_short);
    exp_eff   = at_len ? byte_q[LEN_W-1:0] : exp_base;
    closing   = ((LEN_W'(wp_eff) + LEN_W'(1)) == exp_eff);
    err_sel   = !take ? ERR_OUTSIDE : (too_long ? ERR_TOO_LONG : ERR_TOO_SHORT);

    if (take) begin
      if (len_err)                          status.act = ACT_ERROR;
      else if (!closing)                    status.act = ACT_NONE;
      else if (exp_eff == LEN_W'(HDR_LEN))  status.act = ACT_EMPTY;
      else                                  status.act = ACT_PACKET;
    end else begin
      status.act = dropping ? ACT_NONE : ACT_ERROR;
    end
    status.slot_free = !out_valid || !out_stall;
    status.run_last  = ((LEN_W'(rd_idx) + LEN_W'(1)) == exp_len);
  end

  // Parser state update
  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      exp_len   <= LEN_W'(MAX_PACKET);
      in_packet <= 1'b0;
      dropping  <= 1'b0;
      rd_idx    <= '0;
    end else begin
      if (cmd.commit) begin
        rd_idx <= POS_W'(HDR_LEN);
        if (take) begin
          if (open_pkt) dropping <= 1'b0;
          if (len_err) begin
            in_packet <= 1'b0;
            dropping  <= 1'b1;
            wp        <= wp_eff;
            exp_len   <= exp_base;
          end else if (closing) begin
            in_packet <= 1'b0;
            wp        <= wp_eff;
            exp_len   <= exp_eff;
          end else begin
            in_packet <= 1'b1;
            wp        <= wp_eff + POS_W'(1);
            exp_len   <= exp_eff;
          end
        end else if (!dropping) begin
          in_packet <= 1'b0;
          dropping  <= 1'b1;
        end
      end else if (cmd.load_pay) begin
        rd_idx <= rd_idx + POS_W'(1);
      end
    end
  end

  // Captured byte, header fields and error code
  always_ff @(posedge clk) begin
    if (cmd.capture) byte_q <= rx_byte;
    if (cmd.commit) begin
      err_code_q <= err_sel;
      if (take && wp_eff == POS_W'(ID_LO_POS)) id_lo  <= byte_q;
      if (take && wp_eff == POS_W'(ID_HI_POS)) id_hi  <= byte_q;
      if (take && wp_eff == POS_W'(DEST_POS))  dest_q <= byte_q;
    end
  end

  // Packet store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && take) store[wp_eff] <= byte_q;
    if (cmd.rd_issue) rd_data <= store[rd_idx];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_err || cmd.load_empty || cmd.load_pay) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      kind            <= KIND_ERROR;
      error_code      <= err_code_q;
      packet_id       <= '0;
      dest            <= '0;
      payload_byte    <= '0;
      payload_present <= 1'b0;
      last            <= 1'b1;
    end else if (cmd.load_empty || cmd.load_pay) begin
      kind            <= KIND_CONTENT;
      error_code      <= ERR_OUTSIDE;
      packet_id       <= {id_hi, id_lo};
      dest            <= dest_q;
      payload_byte    <= cmd.load_pay ? rd_data : '0;
      payload_present <= cmd.load_pay;
      last            <= cmd.load_empty || status.run_last;
    end
  end

endmodule

// ===== hw/rtl/framed_packet_receiver.sv =====
`timescale 1ns / 1ps

// Channel | Handshake             | Payload
// --------+-----------------------+---------------------------------------------
// in      | in_valid / in_stall   | rx_byte
// out     | out_valid / out_stall | kind, error_code, packet_id, dest,
//         |                       | payload_byte, payload_present, last
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A byte that gives no result passes through capture and decide; an error then
// waits in its own state to load the output register.
// At packet end each payload result is read from the registered read port of the
// packet store, then loaded into the output register; an empty packet gives one result.
// Reset is synchronous and clears control state; the packet store is not cleared.
// A stalled output holds its item; a new byte is taken once the previous one's
// results are all in the output register.

module framed_packet_receiver import frp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [1:0]  error_code,
  output logic [15:0] packet_id,
  output logic [7:0]  dest,
  output logic [7:0]  payload_byte,
  output logic        payload_present,
  output logic        last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  frp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  frp_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .rx_byte         (rx_byte),
    .cmd             (cmd),
    .status          (status),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .kind            (kind),
    .error_code      (error_code),
    .packet_id       (packet_id),
    .dest            (dest),
    .payload_byte    (payload_byte),
    .payload_present (payload_present),
    .last            (last)
  );

endmodule

// ===== hw/rtl/frp_checker.sv =====
`timescale 1ns / 1ps
`include "framed_packet_receiver_assert.svh"

module frp_checker import frp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        kind,
  input logic [1:0]  error_code,
  input logic [15:0] packet_id,
  input logic        payload_present,
  input logic        last
);

  // A stalled result stays offered
  `FRP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // One byte at a time: the input closes right after an accept
  `FRP_ASSERT_NEXT(a_in_one_at_a_time, clk, rst, in_valid && !in_stall, in_stall)

  // An error result is a run of its own with no content
  `FRP_ASSERT_NOW(a_err_alone, clk, rst, out_valid && kind == KIND_ERROR,
    last && !payload_present && packet_id == 16'd0)

  // Content results carry a zero error code
  `FRP_ASSERT_NOW(a_content_code, clk, rst, out_valid && kind == KIND_CONTENT,
    error_code == ERR_OUTSIDE)

endmodule

bind framed_packet_receiver frp_checker u_frp_checker (.*);
